@@ sv/ktbl_pkg.sv @@
`timescale 1ns / 1ps
package ktbl_pkg;

   localparam int KIND_W  = 2;
   localparam int KEY_W   = 8;
   localparam int TOKEN_W = 32;
   localparam int RATE_W  = 24;
   localparam int COUNT_W = 9;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [TOKEN_W-1:0] TOKEN_MAX = '1;

   // Item kinds.
   localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TICK    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SWEEP   = 2'd2;

   // Register indexes, taken from paddr[3:2].
   localparam logic [1:0] CSR_RULE_ENABLED = 2'd0;
   localparam logic [1:0] CSR_REFILL_RATE  = 2'd1;
   localparam logic [1:0] CSR_BURST_SIZE   = 2'd2;

   typedef enum logic [4:0] {
      S_CLEAR    = 5'b00001,
      S_IDLE     = 5'b00010,
      S_REQ_READ = 5'b00100,
      S_REQ_UPD  = 5'b01000,
      S_SWEEP    = 5'b10000
   } state_type;

endpackage

@@ sv/ktbl_ram.sv @@
`timescale 1ns / 1ps
module ktbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/keyed_token_bucket_limiter.sv @@
`timescale 1ns / 1ps
// Keyed token-bucket limiter for one action.
// An item is taken when start is high and busy is low: req_kind selects a request
// (req_key_index, req_cost), a time tick, or a sweep that evicts buckets idle longer
// than req_idle_limit ticks. Each item gives exactly one result word, shown for one
// cycle with rsp_valid high; the receiver cannot stall, so results are never held.
// Handling after acceptance: a tick, an unused kind or a request while the rule is
// disabled is answered straight from idle; a request passes through memory read,
// refill multiply, then update and write back; a sweep reads one table entry per
// cycle through the single read port. busy stays high meanwhile, so items are handled
// one at a time.
// After reset the block clears every entry of the bucket table with busy high;
// configuration writes through the csr_ port are accepted during that time.
// The user must write configuration only while the block is idle; the block does not enforce it.
module keyed_token_bucket_limiter #(
   parameter int NUM_KEYS  = 256,
   parameter int TIME_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [ktbl_pkg::KIND_W-1:0]       req_kind,
   input  logic [ktbl_pkg::KEY_W-1:0]        req_key_index,
   input  logic [ktbl_pkg::RATE_W-1:0]       req_cost,
   input  logic [ktbl_pkg::TOKEN_W-1:0]      req_idle_limit,
   output logic                              rsp_valid,
   output logic [ktbl_pkg::KIND_W-1:0]       rsp_result_kind,
   output logic                              rsp_allowed,
   output logic [ktbl_pkg::COUNT_W-1:0]      rsp_evicted_count,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ktbl_pkg::CSR_AW-1:0]       csr_paddr,
   input  logic [ktbl_pkg::CSR_DW-1:0]       csr_pwdata,
   output logic [ktbl_pkg::CSR_DW-1:0]       csr_prdata,
   output logic                              csr_pready
);
   import ktbl_pkg::*;

   localparam int KW = $clog2(NUM_KEYS);
   localparam int CW = (TIME_BITS > TOKEN_W) ? TIME_BITS : TOKEN_W;
   localparam int PW = TOKEN_W + RATE_W;

   // Entry layout: valid, tokens, last seen, rate, capacity.
   localparam int CAP_LSB   = 0;
   localparam int RATE_LSB  = CAP_LSB + TOKEN_W;
   localparam int LAST_LSB  = RATE_LSB + RATE_W;
   localparam int TOK_LSB   = LAST_LSB + TIME_BITS;
   localparam int VALID_BIT = TOK_LSB + TOKEN_W;
   localparam int EW        = VALID_BIT + 1;

   // Key reduced modulo NUM_KEYS by restoring subtraction over eight steps.
   function automatic logic [KW-1:0] key_mod(input logic [KEY_W-1:0] k);
      logic [31:0] v;
      v = 32'(k);
      for (int s = KEY_W - 1; s >= 0; s--) begin
         if (v >= (32'(NUM_KEYS) << s)) begin
            v = v - (32'(NUM_KEYS) << s);
         end
      end
      return v[KW-1:0];
   endfunction

   // Configuration registers.
   logic                 rule_enabled_ff, rule_enabled_in;
   logic [RATE_W-1:0]    refill_rate_ff, refill_rate_in;
   logic [TOKEN_W-1:0]   burst_size_ff, burst_size_in;
   logic                 csr_write;

   // Control state.
   state_type            state_ff, state_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [KW-1:0]        clr_ff, clr_in;
   logic [KW-1:0]        sw_rd_ff, sw_rd_in;
   logic                 sw_issue_ff, sw_issue_in;
   logic                 sw_cmp_ff, sw_cmp_in;
   logic [KW-1:0]        sw_cmp_addr_ff, sw_cmp_addr_in;
   logic [COUNT_W-1:0]   sw_count_ff, sw_count_in;

   // Item payload.
   logic [KW-1:0]        key_ff, key_in;
   logic [RATE_W-1:0]    cost_ff, cost_in;
   logic [TOKEN_W-1:0]   limit_ff, limit_in;

   // Refill pipeline.
   logic [TOKEN_W-1:0]   upd_tokens_ff, upd_tokens_in;
   logic [TOKEN_W-1:0]   upd_cap_ff, upd_cap_in;
   logic [RATE_W-1:0]    upd_rate_ff, upd_rate_in;
   logic [PW-1:0]        prod_ff, prod_in;
   logic                 big_ff, big_in;

   // Result registers.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]    rsp_kind_ff, rsp_kind_in;
   logic                 rsp_allowed_ff, rsp_allowed_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   // Memory ports.
   logic                 wr_en;
   logic [KW-1:0]        wr_addr;
   logic [EW-1:0]        wr_data;
   logic [KW-1:0]        rd_addr;
   logic [EW-1:0]        rd_data;

   // Combinational helpers.
   logic                 accept;
   logic                 ent_valid;
   logic [TOKEN_W-1:0]   ent_tokens, ent_cap;
   logic [RATE_W-1:0]    ent_rate;
   logic [TIME_BITS-1:0] ent_last, age;
   logic [CW-1:0]        age_ext;
   logic                 evict;
   logic [TOKEN_W-1:0]   refill, capped;
   logic [TOKEN_W:0]     sum;
   logic                 ok;

   ktbl_ram #(
      .WIDTH (EW),
      .DEPTH (NUM_KEYS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Configuration port: zero wait states, index in paddr[3:2].
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      rule_enabled_in = rule_enabled_ff;
      refill_rate_in  = refill_rate_ff;
      burst_size_in   = burst_size_ff;
      csr_prdata      = '0;
      case (csr_paddr[3:2])
         CSR_RULE_ENABLED: begin
            csr_prdata = CSR_DW'(rule_enabled_ff);
            if (csr_write) begin
               rule_enabled_in = csr_pwdata[0];
            end
         end
         CSR_REFILL_RATE: begin
            csr_prdata = CSR_DW'(refill_rate_ff);
            if (csr_write) begin
               refill_rate_in = csr_pwdata[RATE_W-1:0];
            end
         end
         CSR_BURST_SIZE: begin
            csr_prdata = burst_size_ff;
            if (csr_write) begin
               burst_size_in = csr_pwdata;
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // Fields of the word that the memory returned.
   assign ent_valid  = rd_data[VALID_BIT];
   assign ent_tokens = rd_data[TOK_LSB +: TOKEN_W];
   assign ent_last   = rd_data[LAST_LSB +: TIME_BITS];
   assign ent_rate   = rd_data[RATE_LSB +: RATE_W];
   assign ent_cap    = rd_data[CAP_LSB +: TOKEN_W];

   // Age of the entry in ticks; the subtraction wraps with the time counter.
   assign age     = time_ff - ent_last;
   assign age_ext = CW'(age);
   assign evict   = ent_valid && (age_ext > CW'(limit_ff));

   // Refill saturates when the elapsed span or the product leaves 32 bits.
   always_comb begin
      if (upd_rate_ff == '0) begin
         refill = '0;
      end else if (big_ff || (prod_ff[PW-1:TOKEN_W] != '0)) begin
         refill = TOKEN_MAX;
      end else begin
         refill = prod_ff[TOKEN_W-1:0];
      end
      sum    = {1'b0, upd_tokens_ff} + {1'b0, refill};
      capped = (sum > {1'b0, upd_cap_ff}) ? upd_cap_ff : sum[TOKEN_W-1:0];
      ok     = capped >= TOKEN_W'(cost_ff);
   end

   assign accept = start & ~busy;

   always_comb begin
      state_in       = state_ff;
      time_in        = time_ff;
      clr_in         = clr_ff;
      sw_rd_in       = sw_rd_ff;
      sw_issue_in    = sw_issue_ff;
      sw_cmp_in      = 1'b0;
      sw_cmp_addr_in = sw_cmp_addr_ff;
      sw_count_in    = sw_count_ff;
      key_in         = key_ff;
      cost_in        = cost_ff;
      limit_in       = limit_ff;
      upd_tokens_in  = upd_tokens_ff;
      upd_cap_in     = upd_cap_ff;
      upd_rate_in    = upd_rate_ff;
      prod_in        = prod_ff;
      big_in         = big_ff;
      rsp_valid_in   = 1'b0;
      rsp_kind_in    = rsp_kind_ff;
      rsp_allowed_in = 1'b0;
      rsp_count_in   = '0;
      wr_en          = 1'b0;
      wr_addr        = clr_ff;
      wr_data        = '0;
      rd_addr        = sw_rd_ff;

      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            if (clr_ff == KW'(NUM_KEYS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            rd_addr = key_mod(req_key_index);
            if (accept) begin
               key_in      = key_mod(req_key_index);
               cost_in     = req_cost;
               limit_in    = req_idle_limit;
               rsp_kind_in = req_kind;
               case (req_kind)
                  KIND_REQUEST: begin
                     if (rule_enabled_ff) begin
                        state_in = S_REQ_READ;
                     end else begin
                        rsp_valid_in   = 1'b1;
                        rsp_allowed_in = 1'b1;
                     end
                  end
                  KIND_TICK: begin
                     time_in      = time_ff + 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  KIND_SWEEP: begin
                     state_in    = S_SWEEP;
                     sw_rd_in    = '0;
                     sw_issue_in = 1'b1;
                     sw_count_in = '0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_REQ_READ: begin
            // A bucket not in use starts full with the current rate and burst.
            if (ent_valid) begin
               upd_tokens_in = ent_tokens;
               upd_cap_in    = ent_cap;
               upd_rate_in   = ent_rate;
               big_in        = age_ext > CW'(TOKEN_MAX);
               prod_in       = PW'(age_ext[TOKEN_W-1:0]) * PW'(ent_rate);
            end else begin
               upd_tokens_in = burst_size_ff;
               upd_cap_in    = burst_size_ff;
               upd_rate_in   = refill_rate_ff;
               big_in        = 1'b0;
               prod_in       = '0;
            end
            state_in = S_REQ_UPD;
         end
         S_REQ_UPD: begin
            wr_en   = 1'b1;
            wr_addr = key_ff;
            wr_data[VALID_BIT]             = 1'b1;
            wr_data[TOK_LSB +: TOKEN_W]    = ok ? (capped - TOKEN_W'(cost_ff)) : capped;
            wr_data[LAST_LSB +: TIME_BITS] = time_ff;
            wr_data[RATE_LSB +: RATE_W]    = upd_rate_ff;
            wr_data[CAP_LSB +: TOKEN_W]    = upd_cap_ff;
            rsp_valid_in   = 1'b1;
            rsp_allowed_in = ok;
            state_in       = S_IDLE;
         end
         S_SWEEP: begin
            // Reads run one entry ahead of the compare and write back.
            rd_addr = sw_rd_ff;
            if (sw_issue_ff) begin
               sw_cmp_in      = 1'b1;
               sw_cmp_addr_in = sw_rd_ff;
               if (sw_rd_ff == KW'(NUM_KEYS - 1)) begin
                  sw_issue_in = 1'b0;
               end else begin
                  sw_rd_in = sw_rd_ff + 1'b1;
               end
            end
            if (sw_cmp_ff) begin
               if (evict) begin
                  wr_en              = 1'b1;
                  wr_addr            = sw_cmp_addr_ff;
                  wr_data            = rd_data;
                  wr_data[VALID_BIT] = 1'b0;
                  if (sw_count_ff != COUNT_MAX) begin
                     sw_count_in = sw_count_ff + 1'b1;
                  end
               end
               if (!sw_issue_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = sw_count_in;
                  state_in     = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         time_ff         <= '0;
         clr_ff          <= '0;
         sw_issue_ff     <= 1'b0;
         sw_cmp_ff       <= 1'b0;
         sw_count_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
         rsp_kind_ff     <= '0;
         rsp_allowed_ff  <= 1'b0;
         rsp_count_ff    <= '0;
         rule_enabled_ff <= 1'b0;
         refill_rate_ff  <= RATE_W'(256);
         burst_size_ff   <= TOKEN_W'(2560);
      end else begin
         state_ff        <= state_in;
         time_ff         <= time_in;
         clr_ff          <= clr_in;
         sw_issue_ff     <= sw_issue_in;
         sw_cmp_ff       <= sw_cmp_in;
         sw_count_ff     <= sw_count_in;
         rsp_valid_ff    <= rsp_valid_in;
         rsp_kind_ff     <= rsp_kind_in;
         rsp_allowed_ff  <= rsp_allowed_in;
         rsp_count_ff    <= rsp_count_in;
         rule_enabled_ff <= rule_enabled_in;
         refill_rate_ff  <= refill_rate_in;
         burst_size_ff   <= burst_size_in;
      end
   end

   always_ff @(posedge clock) begin
      sw_rd_ff       <= sw_rd_in;
      sw_cmp_addr_ff <= sw_cmp_addr_in;
      key_ff         <= key_in;
      cost_ff        <= cost_in;
      limit_ff       <= limit_in;
      upd_tokens_ff  <= upd_tokens_in;
      upd_cap_ff     <= upd_cap_in;
      upd_rate_ff    <= upd_rate_in;
      prod_ff        <= prod_in;
      big_ff         <= big_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = rsp_kind_ff;
   assign rsp_allowed       = rsp_allowed_ff;
   assign rsp_evicted_count = rsp_count_ff;

`ifndef ASSERT_OFF
   // A result only leaves when the sequencer has returned to idle.
   a_rsp_in_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("result strobe outside idle");

   // Every accepted word either keeps the block busy or answers at once.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid_ff))
      else $error("accepted word produced no work");

   // Only requests can be admitted.
   a_allowed_request: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_allowed_ff) |-> (rsp_kind_ff == KIND_REQUEST))
      else $error("allowed set on non-request");

   // Only sweeps report evictions.
   a_count_sweep: assert property (@(posedge clock) disable iff (reset)
      (rsp_count_ff != '0) |-> (rsp_kind_ff == KIND_SWEEP))
      else $error("eviction count on non-sweep");

   // The table is written back only in clearing, update or sweep.
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_CLEAR || state_ff == S_REQ_UPD || state_ff == S_SWEEP))
      else $error("table write in wrong state");
`endif

endmodule
